@@ hw/rtl/vwe_pkg.sv @@
// ----------------------------------------------------------------------------
// vwe_pkg: shared definitions for the voxel window excess test
// Volume geometry, field widths, register codes, reset values and the
// control/status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vwe_pkg;

  // volume geometry and store width
  localparam int DIM_X       = 32;
  localparam int DIM_Y       = 32;
  localparam int DIM_Z       = 32;
  localparam int MAX_EXTENT  = 3;
  localparam int COUNT_WIDTH = 16;

  // fixed field widths
  localparam int COORD_W    = 5;
  localparam int IN_COUNT_W = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int EXTENT_W   = 2;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 8;

  // derived sizes
  localparam int VOXELS  = DIM_X * DIM_Y * DIM_Z;
  localparam int ADDR_W  = $clog2(VOXELS);
  localparam int E_W     = $clog2(MAX_EXTENT + 1);
  localparam int D_W     = E_W + 1;
  localparam int WC_W    = COORD_W + 2;
  localparam int WIN_MAX = (2 * MAX_EXTENT + 1) * (2 * MAX_EXTENT + 1) * (2 * MAX_EXTENT + 1);
  localparam int SUM_W   = COUNT_WIDTH + $clog2(WIN_MAX);
  localparam int PROD_W  = SUM_W + CFG_W;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // register reset values
  localparam logic [EXTENT_W-1:0] EXTENT_RST    = EXTENT_W'(1);
  localparam logic [CFG_W-1:0]    SRC_SCALE_RST = CFG_W'(2427);
  localparam logic [CFG_W-1:0]    BG_SCALE_RST  = CFG_W'(2427);
  localparam logic [CFG_W-1:0]    THRESHOLD_RST = CFG_W'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXTENT    = 2'd0,
    CFG_SRC_SCALE = 2'd1,
    CFG_BG_SCALE  = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [EXTENT_W-1:0] extent;
    logic [CFG_W-1:0]    src_scale;
    logic [CFG_W-1:0]    bg_scale;
    logic [CFG_W-1:0]    threshold;
  } cfg_t;

  typedef struct packed {
    logic clear;     // write zeros at the sweep address and advance it
    logic wr_item;   // store the counts of the incoming word
    logic start;     // latch query voxel, reset window counters and sums
    logic issue;     // read the current window voxel and step the counters
    logic mul;       // scale both sums
    logic sub;       // absolute difference of the scaled sums
    logic res_load;  // threshold test into the output register
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic out_busy;
  } sts_t;

  function automatic logic [ADDR_W-1:0] voxel_addr(input int x, input int y, input int z);
    return ADDR_W'((z * DIM_Y + y) * DIM_X + x);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vwe_ram.sv @@
// ----------------------------------------------------------------------------
// vwe_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vwe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/vwe_cfg.sv @@
// ----------------------------------------------------------------------------
// vwe_cfg: configuration registers
// Window extent, the two Q16.16 scale factors and the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module vwe_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vwe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vwe_pkg::CFG_W-1:0]     cfg_data_i,
  output vwe_pkg::cfg_t                      cfg_o
);

  vwe_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (vwe_pkg::cfg_idx_e'(cfg_index_i))
        vwe_pkg::CFG_EXTENT:    cfg_d.extent    = cfg_data_i[vwe_pkg::EXTENT_W-1:0];
        vwe_pkg::CFG_SRC_SCALE: cfg_d.src_scale = cfg_data_i;
        vwe_pkg::CFG_BG_SCALE:  cfg_d.bg_scale  = cfg_data_i;
        vwe_pkg::CFG_THRESHOLD: cfg_d.threshold = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extent    <= vwe_pkg::EXTENT_RST;
      cfg_q.src_scale <= vwe_pkg::SRC_SCALE_RST;
      cfg_q.bg_scale  <= vwe_pkg::BG_SCALE_RST;
      cfg_q.threshold <= vwe_pkg::THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/vwe_dp.sv @@
// ----------------------------------------------------------------------------
// vwe_dp: datapath
// Count stores, clearing sweep, window counters, accumulators, scaling
// multipliers, difference stage and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vwe_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire vwe_pkg::cmd_t                  cmd_i,
  output vwe_pkg::sts_t                       sts_o,
  input  wire vwe_pkg::cfg_t                  cfg_i,
  input  wire logic [vwe_pkg::COORD_W-1:0]    in_x_i,
  input  wire logic [vwe_pkg::COORD_W-1:0]    in_y_i,
  input  wire logic [vwe_pkg::COORD_W-1:0]    in_z_i,
  input  wire logic [vwe_pkg::IN_COUNT_W-1:0] in_src_i,
  input  wire logic [vwe_pkg::IN_COUNT_W-1:0] in_bg_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                out_sig_o,
  output logic                                out_exc_o,
  output logic                                out_def_o
);

  localparam int AW = vwe_pkg::ADDR_W;
  localparam int CW = vwe_pkg::COUNT_WIDTH;
  localparam int DW = vwe_pkg::D_W;
  localparam int WW = vwe_pkg::WC_W;
  localparam int SW = vwe_pkg::SUM_W;
  localparam int PW = vwe_pkg::PROD_W;

  // clearing sweep
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  assign clr_cnt_d = cmd_i.clear ? clr_cnt_q + AW'(1) : clr_cnt_q;
  assign sts_o.clear_last = (clr_cnt_q == AW'(vwe_pkg::VOXELS - 1));

  // query latch and window counters
  logic [vwe_pkg::COORD_W-1:0] vx_q, vy_q, vz_q;
  logic [vwe_pkg::E_W-1:0]     e_q, e_clamp;
  logic signed [DW-1:0]        dx_q, dy_q, dz_q, e_s;

  assign e_clamp = (int'(cfg_i.extent) > vwe_pkg::MAX_EXTENT) ?
                   vwe_pkg::E_W'(vwe_pkg::MAX_EXTENT) : vwe_pkg::E_W'(cfg_i.extent);
  assign e_s = {1'b0, e_q};

  logic dx_end, dy_end, dz_end;
  assign dx_end = (dx_q == e_s);
  assign dy_end = (dy_q == e_s);
  assign dz_end = (dz_q == e_s);
  assign sts_o.scan_last = dx_end && dy_end && dz_end;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      vx_q <= in_x_i;
      vy_q <= in_y_i;
      vz_q <= in_z_i;
      e_q  <= e_clamp;
      dx_q <= -$signed({1'b0, e_clamp});
      dy_q <= -$signed({1'b0, e_clamp});
      dz_q <= -$signed({1'b0, e_clamp});
    end else if (cmd_i.issue) begin
      if (dx_end) begin
        dx_q <= -e_s;
        if (dy_end) begin
          dy_q <= -e_s;
          dz_q <= dz_q + DW'(1);
        end else begin
          dy_q <= dy_q + DW'(1);
        end
      end else begin
        dx_q <= dx_q + DW'(1);
      end
    end
  end

  // window voxel coordinates, signed so that neighbours past an edge drop out
  logic signed [WW-1:0] cx, cy, cz;
  assign cx = $signed({2'b00, vx_q}) + WW'(dx_q);
  assign cy = $signed({2'b00, vy_q}) + WW'(dy_q);
  assign cz = $signed({2'b00, vz_q}) + WW'(dz_q);

  logic win_inside;
  assign win_inside = !cx[WW-1] && (int'(cx) < vwe_pkg::DIM_X) &&
                      !cy[WW-1] && (int'(cy) < vwe_pkg::DIM_Y) &&
                      !cz[WW-1] && (int'(cz) < vwe_pkg::DIM_Z);

  logic [AW-1:0] raddr;
  assign raddr = vwe_pkg::voxel_addr(int'(cx), int'(cy), int'(cz));

  // store write port: clearing sweep or write item
  logic          in_inside;
  logic          ram_we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wsrc, wbg;

  assign in_inside = (int'(in_x_i) < vwe_pkg::DIM_X) && (int'(in_y_i) < vwe_pkg::DIM_Y) &&
                     (int'(in_z_i) < vwe_pkg::DIM_Z);
  assign ram_we = cmd_i.clear || (cmd_i.wr_item && in_inside);
  assign waddr  = cmd_i.clear ? clr_cnt_q :
                  vwe_pkg::voxel_addr(int'(in_x_i), int'(in_y_i), int'(in_z_i));
  assign wsrc   = cmd_i.clear ? '0 : CW'(in_src_i);
  assign wbg    = cmd_i.clear ? '0 : CW'(in_bg_i);

  logic [CW-1:0] src_rdata, bg_rdata;

  vwe_ram #(.WIDTH(CW), .DEPTH(vwe_pkg::VOXELS)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wsrc),
    .raddr_i (raddr),
    .rdata_o (src_rdata)
  );

  vwe_ram #(.WIDTH(CW), .DEPTH(vwe_pkg::VOXELS)) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wbg),
    .raddr_i (raddr),
    .rdata_o (bg_rdata)
  );

  // accumulate in the cycle after the read is issued
  logic          rd_in_q;
  logic [SW-1:0] ssum_q, bsum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ssum_q <= '0;
      bsum_q <= '0;
    end else if (rd_in_q) begin
      ssum_q <= ssum_q + SW'(src_rdata);
      bsum_q <= bsum_q + SW'(bg_rdata);
    end
  end

  // scaling and difference
  logic [PW-1:0] ds_q, db_q, diff_q;
  logic          db_gt_q;
  logic [PW:0]   s_minus_b, b_minus_s;

  assign s_minus_b = {1'b0, ds_q} - {1'b0, db_q};
  assign b_minus_s = {1'b0, db_q} - {1'b0, ds_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      ds_q <= PW'(ssum_q) * PW'(cfg_i.src_scale);
      db_q <= PW'(bsum_q) * PW'(cfg_i.bg_scale);
    end
    if (cmd_i.sub) begin
      db_gt_q <= s_minus_b[PW];
      diff_q  <= s_minus_b[PW] ? b_minus_s[PW-1:0] : s_minus_b[PW-1:0];
    end
  end

  // a set flag implies a nonzero difference, so the borrow gives the direction
  logic sig;
  assign sig = (diff_q[PW-1:vwe_pkg::CFG_W] != '0) ||
               (diff_q[vwe_pkg::CFG_W-1:0] > cfg_i.threshold);

  logic out_vld_q, out_vld_d;
  logic sig_q, exc_q, def_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (cmd_i.res_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      sig_q <= sig;
      exc_q <= sig && !db_gt_q;
      def_q <= sig && db_gt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      rd_in_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      rd_in_q   <= cmd_i.issue && win_inside;
      out_vld_q <= out_vld_d;
    end
  end

  assign sts_o.out_busy = out_vld_q && !out_ready_i;
  assign out_valid_o    = out_vld_q;
  assign out_sig_o      = sig_q;
  assign out_exc_o      = exc_q;
  assign out_def_o      = def_q;

endmodule

`default_nettype wire

@@ hw/rtl/vwe_ctrl.sv @@
// ----------------------------------------------------------------------------
// vwe_ctrl: controller
// Sequences the clearing sweep, write items and the query window scan with its scaling, difference and result steps.
// ----------------------------------------------------------------------------
`default_nettype none

module vwe_ctrl (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_kind_i,
  output logic         in_ready_o,
  input  wire vwe_pkg::sts_t sts_i,
  output vwe_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_SUB   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == vwe_pkg::KIND_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.wr_item = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_MUL;
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/voxel_window_excess_test_core.sv @@
// ----------------------------------------------------------------------------
// voxel_window_excess_test_core: windowed source versus background density test
// Stores source and background counts per voxel and, on a query, tests the
// scaled difference of their sums over a cube around the voxel.
// ----------------------------------------------------------------------------
// After reset the block sweeps both count stores to zero, one voxel per
// cycle; it takes no word during the sweep, while configuration writes are
// taken at any time. A write word is stored as it is accepted and a new word
// may follow at once. A query scans a cube of (2*e+1)^3 voxels, e being the
// extent clamped to the window limit. The window scan reads one voxel per
// cycle through the single read port of the store RAMs; then come scaling,
// difference and threshold test. A finished result waits in the output
// register while the next word is accepted. Write configuration only while
// no query is in flight.
`default_nettype none

module voxel_window_excess_test_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // s_axis_tdata: voxel_x, voxel_y, voxel_z, source_count, background_count
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [vwe_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // s_axis_tuser: kind
  input  wire logic [0:0]                    s_axis_tuser,
  // m_axis_tdata: significant, excess, deficit
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [vwe_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vwe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vwe_pkg::CFG_W-1:0]     cfg_data_i
);

  vwe_pkg::cfg_t cfg;
  vwe_pkg::cmd_t cmd;
  vwe_pkg::sts_t sts;
  logic          out_sig, out_exc, out_def;

  vwe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vwe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_i       (cfg),
    .in_x_i      (s_axis_tdata[4:0]),
    .in_y_i      (s_axis_tdata[9:5]),
    .in_z_i      (s_axis_tdata[14:10]),
    .in_src_i    (s_axis_tdata[30:15]),
    .in_bg_i     (s_axis_tdata[46:31]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sig_o   (out_sig),
    .out_exc_o   (out_exc),
    .out_def_o   (out_def)
  );

  assign m_axis_tdata = {5'b00000, out_def, out_exc, out_sig};

endmodule

`default_nettype wire

@@ hw/rtl/vwe_checker.sv @@
// ----------------------------------------------------------------------------
// vwe_checker: port-level checks for the voxel window excess test
// Watches the top-level ports and flags result and handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

module vwe_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [0:0]                    s_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [vwe_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // the input side is closed after an accepted query
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == vwe_pkg::KIND_QUERY)
    |=> !s_axis_tready)
    else $error("word accepted right after a query");

  a_dir_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
    else $error("excess and deficit both set");

  a_dir_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1] || m_axis_tdata[2]) |-> m_axis_tdata[0])
    else $error("direction flag without significance");

endmodule

bind voxel_window_excess_test_core vwe_checker u_vwe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
